@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL files that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge once reset has been released.
`define SLR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SLR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/slr_pkg.sv @@
// Shared constants, operation codes and control structs of the L-system rewriter.
package slr_pkg;

  localparam int MAX_TARGETS  = 8;
  localparam int MAX_ALTS     = 4;
  localparam int REPLACE_LEN  = 16;
  localparam int SENTENCE_LEN = 1024;

  localparam int ALT_SLOTS = MAX_TARGETS * MAX_ALTS;

  localparam int OP_W     = 2;
  localparam int SYM_W    = 8;
  localparam int CHANCE_W = 16;
  localparam int RND_W    = 16;

  localparam int RULE_W  = $clog2(MAX_TARGETS);
  localparam int RCNT_W  = $clog2(MAX_TARGETS + 1);
  localparam int ALT_W   = $clog2(MAX_ALTS);
  localparam int ACNT_W  = $clog2(MAX_ALTS + 1);
  localparam int SLOT_W  = $clog2(ALT_SLOTS);
  localparam int LEN_W   = $clog2(REPLACE_LEN + 1);
  localparam int K_W     = $clog2(REPLACE_LEN);
  localparam int TEXT_AW = $clog2(ALT_SLOTS * REPLACE_LEN);
  localparam int OCNT_W  = $clog2(SENTENCE_LEN + 1);
  localparam int SUM_W   = CHANCE_W + $clog2(MAX_ALTS);

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 2'd0,
    OP_APPEND  = 2'd1,
    OP_REWRITE = 2'd2,
    OP_NEWGEN  = 2'd3
  } slr_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic add;
    logic append;
    logic newgen;
    logic rw_start;
    logic alt_step;
    logic commit;
    logic emit;
  } slr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    slr_op_e op;
    logic    stopped;
    logic    has_alts;
    logic    alt_last;
    logic    match;
    logic    chosen;
    logic    ovf;
    logic    len_zero;
    logic    emit_last;
    logic    out_free;
  } slr_status_t;

endpackage

@@ rtl/slr_if.sv @@
// Valid/ready stream interfaces for the rewriter's input and result channels.
interface slr_in_if;
  logic                        valid;
  logic                        ready;
  logic [slr_pkg::OP_W-1:0]     operation;
  logic [slr_pkg::SYM_W-1:0]    symbol;
  logic [slr_pkg::CHANCE_W-1:0] chance;
  logic [slr_pkg::SYM_W-1:0]    repl_char;
  logic [slr_pkg::RND_W-1:0]    rnd;

  modport source (output valid, operation, symbol, chance, repl_char, rnd, input ready);
  modport sink   (input valid, operation, symbol, chance, repl_char, rnd, output ready);
endinterface

interface slr_out_if;
  logic                     valid;
  logic                     ready;
  logic [slr_pkg::SYM_W-1:0] out_char;
  logic                     last;
  logic                     overflow;

  modport source (output valid, out_char, last, overflow, input ready);
  modport sink   (input valid, out_char, last, overflow, output ready);
endinterface

@@ rtl/stochastic_lsystem_rewriter.sv @@
// Stochastic L-system rewriter top level; reset is async, active low, empties the tables.
// Load and new-generation items give no beat; a rewrite while stopped gives none either.
// A rewrite reads the alternatives one at a time from a registered store, then checks
// the sentence limit, then emits the chosen text one character per beat.
// A copied symbol or overflow beat is registered at the end of the check; chosen text
// follows one beat per cycle after the check, each held while the result register is full.
`include "assert_macros.svh"

module stochastic_lsystem_rewriter (
  input logic        clk_i,
  input logic        rst_ni,
  slr_in_if.sink     in_i,
  slr_out_if.source  out_o
);
  import slr_pkg::*;

  slr_cmd_t    cmd;
  slr_status_t status;

  slr_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  slr_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .operation_i    (in_i.operation),
    .symbol_i       (in_i.symbol),
    .chance_i       (in_i.chance),
    .repl_char_i    (in_i.repl_char),
    .rnd_i          (in_i.rnd),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .out_char_o     (out_o.out_char),
    .out_last_o     (out_o.last),
    .out_overflow_o (out_o.overflow)
  );

  // An overflow beat carries a zero character and closes the symbol
  `SLR_ASSERT_ALWAYS(a_ovf_beat, out_o.valid && out_o.overflow |-> out_o.out_char == '0 && out_o.last, "overflow beat malformed")
  // An accepted item keeps the block busy for the next cycle
  `SLR_ASSERT(a_busy_after_accept, in_i.valid && in_i.ready |=> !in_i.ready, "ready after accept")
  // Hitting the sentence limit stops the generation
  `SLR_ASSERT(a_stop_on_ovf, cmd.commit && status.ovf |=> status.stopped, "limit did not stop")

endmodule

@@ rtl/slr_datapath.sv @@
// Rule tables, alternative search, sentence counter and result register.
module slr_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  slr_pkg::slr_cmd_t            cmd_i,
  output slr_pkg::slr_status_t         status_o,
  input  logic [slr_pkg::OP_W-1:0]     operation_i,
  input  logic [slr_pkg::SYM_W-1:0]    symbol_i,
  input  logic [slr_pkg::CHANCE_W-1:0] chance_i,
  input  logic [slr_pkg::SYM_W-1:0]    repl_char_i,
  input  logic [slr_pkg::RND_W-1:0]    rnd_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [slr_pkg::SYM_W-1:0]    out_char_o,
  output logic                         out_last_o,
  output logic                         out_overflow_o
);
  import slr_pkg::*;

  // Latched input item
  slr_op_e             op_q;
  logic [SYM_W-1:0]    sym_q;
  logic [CHANCE_W-1:0] chance_q;
  logic [SYM_W-1:0]    rc_q;
  logic [RND_W-1:0]    rnd_q;

  // Rule table and load pointer
  logic [SYM_W-1:0]  rule_symbol_q [MAX_TARGETS];
  logic [ACNT_W-1:0] rule_acnt_q   [MAX_TARGETS];
  logic [RCNT_W-1:0] rule_cnt_q;
  logic [RULE_W-1:0] load_rule_q;
  logic [ALT_W-1:0]  load_alt_q;
  logic              load_valid_q;
  logic [LEN_W-1:0]  load_len_q;

  // Sentence state
  logic [OCNT_W-1:0] out_cnt_q;
  logic              stopped_q;

  // Search state
  logic [RULE_W-1:0] rule_q;
  logic [ACNT_W-1:0] acnt_q;
  logic [ALT_W-1:0]  a_q;
  logic [SUM_W-1:0]  sum_q;
  logic              chosen_q;
  logic [LEN_W-1:0]  len_q;
  logic [SLOT_W-1:0] slot_q;
  logic [K_W-1:0]    k_q;
  logic [K_W-1:0]    k_d;

  // Memories
  logic [CHANCE_W-1:0] chance_mem [ALT_SLOTS];
  logic [LEN_W-1:0]    length_mem [ALT_SLOTS];
  logic [SYM_W-1:0]    text_mem   [ALT_SLOTS * REPLACE_LEN];
  logic [CHANCE_W-1:0] chance_rd;
  logic [LEN_W-1:0]    len_rd;
  logic [SYM_W-1:0]    text_rd;

  // Result register
  logic             out_valid_q;
  logic [SYM_W-1:0] out_char_q;
  logic             out_last_q;
  logic             out_ovf_q;

  logic              hit;
  logic [RULE_W-1:0] hit_idx;
  logic [ACNT_W-1:0] hit_acnt;
  logic [RULE_W-1:0] new_idx;
  logic              table_full;
  logic [RULE_W-1:0] add_rule;
  logic [ACNT_W-1:0] add_acnt;
  logic              add_ok;
  logic [SLOT_W-1:0] add_slot;
  logic [SLOT_W-1:0] load_slot;
  logic              app_ok;
  logic              len_we;
  logic [SLOT_W-1:0] len_waddr;
  logic [LEN_W-1:0]  len_wdata;
  logic [TEXT_AW-1:0] text_waddr;
  logic [TEXT_AW-1:0] text_raddr;
  logic [SLOT_W-1:0] rd_slot;
  logic [SUM_W-1:0]  sum_next;
  logic              match;
  logic              ovf;
  logic              emit_last;
  logic              out_free;
  logic              single_load;

  // Capture the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q     <= slr_op_e'(operation_i);
      sym_q    <= symbol_i;
      chance_q <= chance_i;
      rc_q     <= repl_char_i;
      rnd_q    <= rnd_i;
    end
  end

  // Look up the symbol's rule, lowest index first
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = MAX_TARGETS - 1; i >= 0; i--) begin
      if (RCNT_W'(i) < rule_cnt_q && rule_symbol_q[i] == sym_q) begin
        hit     = 1'b1;
        hit_idx = RULE_W'(i);
      end
    end
  end

  assign hit_acnt = rule_acnt_q[hit_idx];

  // Decode an add: existing rule or a fresh one
  assign new_idx    = rule_cnt_q[RULE_W-1:0];
  assign table_full = rule_cnt_q >= RCNT_W'(MAX_TARGETS);
  assign add_rule   = hit ? hit_idx : new_idx;
  assign add_acnt   = hit ? hit_acnt : '0;
  assign add_ok     = (hit || !table_full) && (add_acnt < ACNT_W'(MAX_ALTS));
  assign add_slot   = SLOT_W'(int'(add_rule) * MAX_ALTS + int'(add_acnt));

  // Decode an append to the open alternative
  assign load_slot  = SLOT_W'(int'(load_rule_q) * MAX_ALTS + int'(load_alt_q));
  assign app_ok     = load_valid_q && (load_len_q < LEN_W'(REPLACE_LEN));
  assign text_waddr = TEXT_AW'(int'(load_slot) * REPLACE_LEN + int'(load_len_q));

  // Length store takes either an add (cleared) or an append (grown)
  always_comb begin
    len_we    = 1'b0;
    len_waddr = load_slot;
    len_wdata = load_len_q + LEN_W'(1);
    if (cmd_i.add && add_ok) begin
      len_we    = 1'b1;
      len_waddr = add_slot;
      len_wdata = '0;
    end else if (cmd_i.append && app_ok) begin
      len_we = 1'b1;
    end
  end

  // Rule symbols hold no reset value
  always_ff @(posedge clk_i) begin
    if (cmd_i.add && add_ok && !hit) begin
      rule_symbol_q[new_idx] <= sym_q;
    end
  end

  // Rule counts, load pointer and sentence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TARGETS; i++) begin
        rule_acnt_q[i] <= '0;
      end
      rule_cnt_q   <= '0;
      load_rule_q  <= '0;
      load_alt_q   <= '0;
      load_valid_q <= 1'b0;
      load_len_q   <= '0;
      out_cnt_q    <= '0;
      stopped_q    <= 1'b0;
    end else begin
      if (cmd_i.add) begin
        if (add_ok) begin
          if (!hit) begin
            rule_cnt_q <= rule_cnt_q + RCNT_W'(1);
          end
          rule_acnt_q[add_rule] <= add_acnt + ACNT_W'(1);
          load_rule_q  <= add_rule;
          load_alt_q   <= add_acnt[ALT_W-1:0];
          load_valid_q <= 1'b1;
          load_len_q   <= '0;
        end else begin
          load_valid_q <= 1'b0;
        end
      end
      if (cmd_i.append && app_ok) begin
        load_len_q <= load_len_q + LEN_W'(1);
      end
      if (cmd_i.newgen) begin
        out_cnt_q <= '0;
        stopped_q <= 1'b0;
      end
      if (cmd_i.commit) begin
        if (ovf) begin
          stopped_q <= 1'b1;
        end else begin
          out_cnt_q <= out_cnt_q + OCNT_W'(len_q);
        end
      end
    end
  end

  // Alternative chance and length stores
  assign rd_slot = SLOT_W'(int'(rule_q) * MAX_ALTS + int'(a_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.add && add_ok) begin
      chance_mem[add_slot] <= chance_q;
    end
    if (len_we) begin
      length_mem[len_waddr] <= len_wdata;
    end
    chance_rd <= chance_mem[rd_slot];
    len_rd    <= length_mem[rd_slot];
  end

  // Replacement text store
  assign text_raddr = TEXT_AW'(int'(slot_q) * REPLACE_LEN + int'(k_d));

  always_ff @(posedge clk_i) begin
    if (cmd_i.append && app_ok) begin
      text_mem[text_waddr] <= rc_q;
    end
    text_rd <= text_mem[text_raddr];
  end

  // Running sum against the random draw
  assign sum_next = sum_q + SUM_W'(chance_rd);
  assign match    = SUM_W'(rnd_q) < sum_next;

  // Sentence limit check
  assign ovf = ({1'b0, out_cnt_q} + (OCNT_W + 1)'(len_q)) > (OCNT_W + 1)'(SENTENCE_LEN);

  assign emit_last = (LEN_W'(k_q) + LEN_W'(1)) == len_q;

  // Advance the character index
  always_comb begin
    k_d = k_q;
    if (cmd_i.commit) begin
      k_d = '0;
    end else if (cmd_i.emit) begin
      k_d = k_q + K_W'(1);
    end
  end

  // Search registers
  always_ff @(posedge clk_i) begin
    k_q <= k_d;
    if (cmd_i.rw_start) begin
      rule_q   <= hit_idx;
      acnt_q   <= hit_acnt;
      a_q      <= '0;
      sum_q    <= '0;
      chosen_q <= 1'b0;
      len_q    <= LEN_W'(1);
    end else if (cmd_i.alt_step) begin
      sum_q <= sum_next;
      if (match) begin
        chosen_q <= 1'b1;
        len_q    <= len_rd;
        slot_q   <= rd_slot;
      end else begin
        a_q <= a_q + ALT_W'(1);
      end
    end
  end

  // Result register: hold until taken
  assign out_free    = !out_valid_q || out_ready_i;
  assign single_load = cmd_i.commit && (ovf || !chosen_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (single_load || cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (single_load) begin
      out_char_q <= ovf ? '0 : sym_q;
      out_last_q <= 1'b1;
      out_ovf_q  <= ovf;
    end else if (cmd_i.emit) begin
      out_char_q <= text_rd;
      out_last_q <= emit_last;
      out_ovf_q  <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_char_o     = out_char_q;
  assign out_last_o     = out_last_q;
  assign out_overflow_o = out_ovf_q;

  // Status to the controller
  assign status_o.op        = op_q;
  assign status_o.stopped   = stopped_q;
  assign status_o.has_alts  = hit && (hit_acnt != '0);
  assign status_o.alt_last  = (ACNT_W'(a_q) + ACNT_W'(1)) == acnt_q;
  assign status_o.match     = match;
  assign status_o.chosen    = chosen_q;
  assign status_o.ovf       = ovf;
  assign status_o.len_zero  = len_q == '0;
  assign status_o.emit_last = emit_last;
  assign status_o.out_free  = out_free;

endmodule

@@ rtl/slr_controller.sv @@
// Sequencer for load, rewrite and emit steps of the rewriter.
module slr_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  slr_pkg::slr_status_t status_i,
  output slr_pkg::slr_cmd_t    cmd_o
);
  import slr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0] state_q;
  logic [2:0] state_d;

  assign in_ready_o = state_q == S_IDLE;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        unique case (status_i.op)
          OP_ADD:    cmd_o.add    = 1'b1;
          OP_APPEND: cmd_o.append = 1'b1;
          OP_NEWGEN: cmd_o.newgen = 1'b1;
          OP_REWRITE: begin
            if (!status_i.stopped) begin
              cmd_o.rw_start = 1'b1;
              state_d        = status_i.has_alts ? S_RD : S_CHK;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_RD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        cmd_o.alt_step = 1'b1;
        state_d        = (status_i.match || status_i.alt_last) ? S_CHK : S_RD;
      end
      S_CHK: begin
        if (status_i.ovf || !status_i.chosen) begin
          // single result: wait for room in the result register
          if (status_i.out_free) begin
            cmd_o.commit = 1'b1;
            state_d      = S_IDLE;
          end
        end else begin
          cmd_o.commit = 1'b1;
          state_d      = status_i.len_zero ? S_IDLE : S_EMIT;
        end
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.emit_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
